FILE: rtl/sha1bs_pkg.sv
// ----------------------------------------------------------------------------
// sha1bs_pkg
// Shared constants and control types for the SHA-1 byte stream hasher.
// ----------------------------------------------------------------------------
package sha1bs_pkg;

  localparam int unsigned ROUNDS      = 80;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned LEN_POS     = 56;
  localparam int unsigned NUM_WORDS   = 5;

  localparam logic [31:0] H_INIT [NUM_WORDS] = '{
    32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
  };

  localparam logic [31:0] K_0 = 32'h5A82_7999;
  localparam logic [31:0] K_1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K_2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K_3 = 32'hCA62_C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // operation of the round unit in one cycle
  typedef enum logic [2:0] {
    RW_HOLD,
    RW_LOAD,
    RW_ROUND,
    RW_ADD,
    RW_ROT,
    RW_INIT
  } rnd_op_t;

  typedef struct packed {
    rnd_op_t    op;
    logic [6:0] rnd;
  } rnd_ctl_t;

  typedef struct packed {
    logic       byte_en;
    logic       word_en;
    logic       round_en;
    logic [7:0] byte_val;
  } sched_ctl_t;

endpackage

FILE: rtl/sha1bs_if.sv
// ----------------------------------------------------------------------------
// sha1bs_in_if / sha1bs_out_if
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
interface sha1bs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, output data_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

interface sha1bs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

FILE: rtl/sha1bs_sched.sv
// ----------------------------------------------------------------------------
// sha1bs_sched
// Byte packer and 16-word message schedule shift line.
// ----------------------------------------------------------------------------
module sha1bs_sched import sha1bs_pkg::*; (
  input  logic        clk,
  input  sched_ctl_t  ctl,
  output logic [31:0] w_out
);

  logic [23:0] acc_r;
  logic [31:0] sr_r [16];
  logic [31:0] mix;
  logic [31:0] new_w;

  assign mix   = sr_r[13] ^ sr_r[8] ^ sr_r[2] ^ sr_r[0];
  assign new_w = ctl.round_en ? {mix[30:0], mix[31]} : {acc_r, ctl.byte_val};
  assign w_out = sr_r[0];

  always_ff @(posedge clk) begin
    if (ctl.byte_en) begin
      acc_r <= {acc_r[15:0], ctl.byte_val};
    end
    // oldest word sits at index 0
    if (ctl.round_en || (ctl.byte_en && ctl.word_en)) begin
      for (int j = 0; j < 15; j++) begin
        sr_r[j] <= sr_r[j+1];
      end
      sr_r[15] <= new_w;
    end
  end

endmodule

FILE: rtl/sha1bs_round.sv
// ----------------------------------------------------------------------------
// sha1bs_round
// Shared SHA-1 round unit with working and chaining registers.
// ----------------------------------------------------------------------------
module sha1bs_round import sha1bs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  rnd_ctl_t    ctl,
  input  logic [31:0] w_in,
  output logic [31:0] digest_word
);

  logic [31:0] ch_r [NUM_WORDS];
  logic [31:0] wk_r [NUM_WORDS];
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;
  logic [31:0] a, b, c, d, e;

  assign a = wk_r[0];
  assign b = wk_r[1];
  assign c = wk_r[2];
  assign d = wk_r[3];
  assign e = wk_r[4];

  always_comb begin
    if (ctl.rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K_0;
    end else if (ctl.rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = K_1;
    end else if (ctl.rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_2;
    end else begin
      f = b ^ c ^ d;
      k = K_3;
    end
    t = {a[26:0], a[31:27]} + f + e + k + w_in;
  end

  assign digest_word = ch_r[0];

  always_ff @(posedge clk) begin
    case (ctl.op)
      RW_LOAD: begin
        for (int i = 0; i < NUM_WORDS; i++) wk_r[i] <= ch_r[i];
      end
      RW_ROUND: begin
        wk_r[4] <= d;
        wk_r[3] <= c;
        wk_r[2] <= {b[1:0], b[31:2]};
        wk_r[1] <= a;
        wk_r[0] <= t;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WORDS; i++) ch_r[i] <= H_INIT[i];
    end else begin
      case (ctl.op)
        RW_ADD: begin
          for (int i = 0; i < NUM_WORDS; i++) ch_r[i] <= ch_r[i] + wk_r[i];
        end
        // rotate so the next digest word shows at index 0
        RW_ROT: begin
          for (int i = 0; i < NUM_WORDS - 1; i++) ch_r[i] <= ch_r[i+1];
          ch_r[NUM_WORDS-1] <= ch_r[0];
        end
        RW_INIT: begin
          for (int i = 0; i < NUM_WORDS; i++) ch_r[i] <= H_INIT[i];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/sha1_byte_stream_hasher.sv
// A beat that neither fills a block nor ends the message is taken and ready stays high.
// A beat that completes a 64-byte block holds ready low through the 80 rounds of the
// single round unit and then the chaining add. End of message: padding is fed one byte
// a cycle, paused while a full block is hashed (9 to 72 bytes, one or two blocks),
// then five digest beats, one per cycle when the sink is ready.
// Reset (synchronous, active low): chaining words to the initial values, counts cleared.
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher
// SHA-1 digest of a byte stream with one shared round unit and a sequencer.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher import sha1bs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  sha1bs_in_if.sink         in_ch,
  sha1bs_out_if.source      out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_ADD,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_ONE,
    PH_ZERO,
    PH_LEN
  } pad_ph_t;

  state_t      state_r, state_nxt;
  pad_ph_t     ph_r, ph_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [60:0] count_r, count_nxt;
  logic        eom_r, eom_nxt;
  logic [2:0]  len_idx_r, len_idx_nxt;
  logic        len_done_r, len_done_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;

  sched_ctl_t  sctl;
  rnd_ctl_t    rctl;
  logic [31:0] w_cur;
  logic [31:0] digest;
  logic [63:0] bit_len;
  logic [7:0]  len_byte;
  logic        blk_full;

  assign bit_len  = {count_r, 3'b000};
  assign len_byte = bit_len[8*(7 - len_idx_r) +: 8];
  assign blk_full = (fill_r == 6'(BLOCK_BYTES - 1));

  always_comb begin
    state_nxt    = state_r;
    ph_nxt       = ph_r;
    fill_nxt     = fill_r;
    count_nxt    = count_r;
    eom_nxt      = eom_r;
    len_idx_nxt  = len_idx_r;
    len_done_nxt = len_done_r;
    rnd_nxt      = rnd_r;
    out_idx_nxt  = out_idx_r;
    sctl         = '0;
    rctl.op      = RW_HOLD;
    rctl.rnd     = rnd_r;
    in_ch.ready  = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          eom_nxt      = in_ch.end_of_message;
          ph_nxt       = PH_ONE;
          len_idx_nxt  = '0;
          len_done_nxt = 1'b0;
          if (in_ch.byte_present) begin
            count_nxt     = count_r + 61'd1;
            sctl.byte_en  = 1'b1;
            sctl.byte_val = in_ch.data_byte;
            sctl.word_en  = (fill_r[1:0] == 2'b11);
            fill_nxt      = fill_r + 6'd1;
          end
          if (in_ch.byte_present && blk_full) begin
            rctl.op   = RW_LOAD;
            rnd_nxt   = '0;
            state_nxt = S_ROUND;
          end else if (in_ch.end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        sctl.byte_en = 1'b1;
        sctl.word_en = (fill_r[1:0] == 2'b11);
        fill_nxt     = fill_r + 6'd1;
        case (ph_r)
          PH_ONE:  sctl.byte_val = PAD_BYTE;
          PH_ZERO: sctl.byte_val = 8'h00;
          default: sctl.byte_val = len_byte;
        endcase
        if (ph_r == PH_LEN) begin
          len_idx_nxt = len_idx_r + 3'd1;
          if (len_idx_r == 3'd7) len_done_nxt = 1'b1;
        end else begin
          // length field starts at byte 56 of the last block
          ph_nxt = (fill_r == 6'(LEN_POS - 1)) ? PH_LEN : PH_ZERO;
        end
        if (blk_full) begin
          rctl.op   = RW_LOAD;
          rnd_nxt   = '0;
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        rctl.op       = RW_ROUND;
        sctl.round_en = 1'b1;
        rnd_nxt       = rnd_r + 7'd1;
        if (rnd_r == 7'(ROUNDS - 1)) state_nxt = S_ADD;
      end
      S_ADD: begin
        rctl.op = RW_ADD;
        if (len_done_r) begin
          out_idx_nxt = '0;
          state_nxt   = S_OUT;
        end else if (eom_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          if (out_idx_r == 3'(NUM_WORDS - 1)) begin
            rctl.op      = RW_INIT;
            count_nxt    = '0;
            eom_nxt      = 1'b0;
            len_done_nxt = 1'b0;
            state_nxt    = S_IDLE;
          end else begin
            rctl.op     = RW_ROT;
            out_idx_nxt = out_idx_r + 3'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ph_r       <= PH_ONE;
      fill_r     <= '0;
      count_r    <= '0;
      eom_r      <= 1'b0;
      len_idx_r  <= '0;
      len_done_r <= 1'b0;
      rnd_r      <= '0;
      out_idx_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      ph_r       <= ph_nxt;
      fill_r     <= fill_nxt;
      count_r    <= count_nxt;
      eom_r      <= eom_nxt;
      len_idx_r  <= len_idx_nxt;
      len_done_r <= len_done_nxt;
      rnd_r      <= rnd_nxt;
      out_idx_r  <= out_idx_nxt;
    end
  end

  assign out_ch.valid       = (state_r == S_OUT);
  assign out_ch.digest_word = digest;
  assign out_ch.word_index  = out_idx_r;
  assign out_ch.last_word   = (out_idx_r == 3'(NUM_WORDS - 1));

  sha1bs_sched u_sched (
    .clk   (clk),
    .ctl   (sctl),
    .w_out (w_cur)
  );

  sha1bs_round u_round (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (rctl),
    .w_in        (w_cur),
    .digest_word (digest)
  );

endmodule

FILE: rtl/sha1bs_chk.sv
// ----------------------------------------------------------------------------
// sha1bs_chk
// Port-level checks of the SHA-1 byte stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
module sha1bs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_eom,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word,
  input logic [2:0]  out_index,
  input logic        out_last
);

  // a stalled digest beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_index))
    else $error("digest beat changed while stalled");

  a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_index == 3'd0)
    else $error("digest does not start at word 0");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && out_index == $past(out_index) + 3'd1)
    else $error("digest words out of order");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid && in_ready)
    else $error("hasher not back to idle after last digest word");

  // only a closing beat leads to digest output
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_eom |=> !out_valid)
    else $error("digest output without end of message");

endmodule

bind sha1_byte_stream_hasher sha1bs_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_eom    (in_ch.end_of_message),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word  (out_ch.digest_word),
  .out_index (out_ch.word_index),
  .out_last  (out_ch.last_word)
);
